@@ rtl/tccs_pkg.sv @@
// shared types and constants of the toggle-confirm chunk sender
`timescale 1ns / 1ps
package tccs_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_START   = 2'd1,
		CMD_CHUNK   = 2'd2,
		CMD_CONFIRM = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_SEND        = 3'd1,
		PH_RESYNC      = 3'd2,
		PH_RESYNC_SEND = 3'd3,
		PH_WAIT        = 3'd4
	} phase_t;

	typedef enum logic {
		FSM_IDLE   = 1'b0,
		FSM_STREAM = 1'b1
	} fsm_t;

	localparam logic REG_MAX_INDEX  = 1'b0;
	localparam logic REG_WAIT_LIMIT = 1'b1;

	localparam logic [15:0] WAIT_LIMIT_RST = 16'd80;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  byte_addr;
		logic [7:0]  byte_value;
		logic [7:0]  msg_length;
		logic [4:0]  max_len;
		logic        confirm_bit;
	} req_t;

	typedef struct packed {
		logic [7:0]  package_index;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        last;
		logic [2:0]  sender_state;
	} rsp_t;

endpackage

@@ rtl/tccs_stream_if.sv @@
// valid/ready item channel
`timescale 1ns / 1ps
interface tccs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/toggle_confirm_chunk_sender_unit.sv @@
// toggle-confirm chunk sender: message store, sender state and chunk streaming
`timescale 1ns / 1ps
// Stop-and-wait message sender. Write, start and confirm items produce nothing. A chunk
// request that yields n bytes (n up to MAX_CHUNK) streams them out one per cycle while
// the output is not held, from the synchronous message memory: the item loads the read
// pointer and byte count, each byte is read into rdata_s1 and then moved to the output
// register, and the next item is taken once the last byte has left. A request with no
// bytes to send gives its single result in the cycle after it is taken. The one read
// port of the message memory sets the streaming rate. The memory has no reset;
// entries must be written before they are sent. Bytes are addressed modulo MSG_BYTES.
module toggle_confirm_chunk_sender_unit #(
	parameter int MSG_BYTES = 256,
	parameter int MAX_CHUNK = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	tccs_stream_if.sink          req,
	tccs_stream_if.source        rsp
);
	import tccs_pkg::*;

	localparam int AW = $clog2(MSG_BYTES);

	// remainder of an 8-bit value by MSG_BYTES (at least 16, so four steps suffice)
	function automatic logic [AW-1:0] mod_msg(input logic [7:0] v);
		logic [11:0] r;
		r = {4'b0, v};
		for (int k = 3; k >= 0; k--) begin
			if (r >= (12'(MSG_BYTES) << k)) begin
				r = r - (12'(MSG_BYTES) << k);
			end
		end
		return AW'(r);
	endfunction

	logic [7:0] mem [MSG_BYTES];

	fsm_t        fsm_q, fsm_d;
	phase_t      phase_q;
	logic        exp_q;
	logic [16:0] miss_q;
	logic [7:0]  off_q;
	logic [7:0]  pcnt_q;
	logic [4:0]  chunk_q;
	logic [7:0]  mlen_q;
	logic [7:0]  maxidx_q;
	logic [15:0] wlim_q;

	logic [AW-1:0] ptr_q;
	logic [4:0]    rem_q;
	logic [7:0]    idx_q;
	logic          rd_valid_s1;
	logic [7:0]    rdata_s1;
	logic          rlast_s1;

	logic        out_valid_q;
	rsp_t        out_q;

	logic        acc, out_free, issue, move, start, single, load;
	logic [7:0]  remain;
	logic [5:0]  cap6;
	logic [4:0]  cap, n;
	logic [7:0]  idx_calc, single_idx;
	logic [16:0] miss_inc;
	logic        miss_over;
	logic [7:0]  off_sum;
	req_t        item;

	assign item      = req.payload;
	assign remain    = mlen_q - off_q;
	assign cap6      = ({1'b0, item.max_len} > 6'(MAX_CHUNK)) ? 6'(MAX_CHUNK)
	                                                          : {1'b0, item.max_len};
	assign cap       = cap6[4:0];
	assign n         = (remain < {3'b0, cap}) ? remain[4:0] : cap;
	assign idx_calc  = (pcnt_q > 8'd1 && ({1'b0, off_q} + {4'b0, n}) >= {1'b0, mlen_q})
	                   ? 8'd0 : pcnt_q;
	assign miss_inc  = (miss_q == 17'h1FFFF) ? miss_q : miss_q + 17'd1;
	assign miss_over = miss_inc > {1'b0, wlim_q};
	assign off_sum   = off_q + {3'b0, chunk_q};

	always_comb begin
		unique case (phase_q)
			PH_RESYNC, PH_RESYNC_SEND: single_idx = maxidx_q;
			PH_SEND:                   single_idx = idx_calc;
			default:                   single_idx = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_IDLE;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_comb begin
		out_free  = !out_valid_q || rsp.ready;
		req.ready = (fsm_q == FSM_IDLE) && out_free;
		acc       = req.valid && req.ready;
		start     = acc && item.cmd == CMD_CHUNK && phase_q == PH_SEND && n != 5'd0;
		single    = acc && item.cmd == CMD_CHUNK && !start;
		issue     = (fsm_q == FSM_STREAM) && rem_q != 5'd0 && (!rd_valid_s1 || out_free);
		move      = rd_valid_s1 && out_free;
		load      = single || move;
		fsm_d     = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (start) begin
					fsm_d = FSM_STREAM;
				end
			end
			FSM_STREAM: begin
				if (rem_q == 5'd0 && (!rd_valid_s1 || move)) begin
					fsm_d = FSM_IDLE;
				end
			end
			default: fsm_d = FSM_IDLE;
		endcase
	end

	// sender state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			exp_q    <= 1'b1;
			miss_q   <= '0;
			off_q    <= '0;
			pcnt_q   <= 8'd1;
			chunk_q  <= '0;
			mlen_q   <= '0;
			maxidx_q <= '0;
			wlim_q   <= WAIT_LIMIT_RST;
		end else if (cfg_we && cfg_index == REG_MAX_INDEX) begin
			maxidx_q <= cfg_data[7:0];
			if (cfg_data[7:0] != maxidx_q) begin
				phase_q <= PH_IDLE;
				exp_q   <= 1'b1;
				miss_q  <= '0;
				off_q   <= '0;
				pcnt_q  <= 8'd1;
				chunk_q <= '0;
				wlim_q  <= WAIT_LIMIT_RST;
			end
		end else if (cfg_we && cfg_index == REG_WAIT_LIMIT) begin
			wlim_q <= cfg_data;
		end else if (acc) begin
			unique case (item.cmd)
				CMD_START: begin
					mlen_q  <= item.msg_length;
					off_q   <= '0;
					pcnt_q  <= 8'd1;
					miss_q  <= '0;
					phase_q <= (phase_q == PH_IDLE) ? PH_SEND : PH_RESYNC_SEND;
				end
				CMD_CONFIRM: begin
					unique case (phase_q)
						PH_SEND: begin
							if (item.confirm_bit != exp_q) begin
								miss_q <= miss_inc;
								if (miss_over) begin
									exp_q   <= ~item.confirm_bit;
									phase_q <= PH_RESYNC;
								end
							end else begin
								off_q <= off_sum;
								if (off_sum >= mlen_q) begin
									phase_q <= (pcnt_q == 8'd1) ? PH_WAIT : PH_IDLE;
								end
								pcnt_q <= pcnt_q + 8'd1;
								exp_q  <= ~exp_q;
								miss_q <= '0;
							end
						end
						PH_RESYNC, PH_RESYNC_SEND, PH_WAIT: begin
							if (item.confirm_bit == exp_q) begin
								phase_q <= (phase_q == PH_RESYNC_SEND) ? PH_SEND : PH_IDLE;
								exp_q   <= ~item.confirm_bit;
							end else if (phase_q == PH_WAIT) begin
								miss_q <= miss_inc;
								if (miss_over) begin
									exp_q   <= ~item.confirm_bit;
									phase_q <= PH_RESYNC;
								end
							end
						end
						default: ;
					endcase
				end
				CMD_CHUNK: begin
					chunk_q <= (phase_q == PH_SEND) ? n : 5'd0;
				end
				default: ;
			endcase
		end
	end

	// message memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (acc && item.cmd == CMD_WRITE) begin
			mem[mod_msg(item.byte_addr)] <= item.byte_value;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[ptr_q];
			rlast_s1 <= (rem_q == 5'd1);
		end
	end

	// stream control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				ptr_q <= mod_msg(off_q);
				rem_q <= n;
				idx_q <= idx_calc;
			end else if (issue) begin
				ptr_q <= (ptr_q == AW'(MSG_BYTES - 1)) ? '0 : ptr_q + 1'b1;
				rem_q <= rem_q - 5'd1;
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.package_index <= idx_q;
			out_q.payload_byte  <= rdata_s1;
			out_q.byte_valid    <= 1'b1;
			out_q.last          <= rlast_s1;
			out_q.sender_state  <= phase_q;
		end else if (single) begin
			out_q.package_index <= single_idx;
			out_q.payload_byte  <= 8'd0;
			out_q.byte_valid    <= 1'b0;
			out_q.last          <= 1'b1;
			out_q.sender_state  <= phase_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.payload.byte_valid |-> rsp.payload.last)
		else $error("result without byte must close its item");

	a_no_take_while_stream: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == FSM_STREAM |-> !req.ready)
		else $error("item taken while a chunk streams");

	a_read_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 || rem_q != 5'd0 |-> fsm_q == FSM_STREAM)
		else $error("memory read outside a chunk");

	a_start_streams: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> fsm_q == FSM_STREAM && rem_q != 5'd0)
		else $error("chunk with bytes did not start streaming");

endmodule
